// ===== rtl/rpmsl_pkg.sv =====
// Package for the RPM shift-light bar core.
// Holds widths, mode codes, bar geometry and the controller/datapath interface structs.
// No dependencies.
package rpmsl_pkg;

    // Bar geometry. The LED count is fixed by the one result port per LED.
    localparam int LED_COUNT = 9;
    localparam int LED_IDX_W = $clog2(LED_COUNT);

    // Field widths.
    localparam int RPM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int LEVEL_W    = 8;
    localparam int MODE_W     = 2;

    // The span from the start point to redline is at most a quarter of the
    // full scale, rounded up, so it fits in one bit less than the speed.
    localparam int RANGE_W = RPM_W - 1;

    // Divider sizing: the ramp numerator is at most range*255.
    localparam int DIV_W     = RANGE_W + LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Segment bounds i*range/LED_COUNT use a reciprocal multiply. The product
    // i*range stays far below 2^RECIP_SHIFT / (rounding error), so it is exact.
    localparam int BOUND_W     = RANGE_W + LED_IDX_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + LED_COUNT - 1) / LED_COUNT;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int PROD_W      = BOUND_W + RECIP_W;

    localparam logic [LEVEL_W-1:0]    FULL_LEVEL     = '1;
    localparam logic [INTERVAL_W-1:0] BLINK_RESET_MS = 16'd100;

    // Configuration register index (byte address bit 2).
    localparam logic REG_BLINK_INTERVAL = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_BLINK = 2'd2
    } bar_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // Latch a new input beat.
        logic blink_step;   // Run the blink timer once.
        logic div_active;   // Start the active-index division.
        logic take_active;  // Latch the active index.
        logic seg_prod;     // Form the bound products.
        logic seg_lo;       // Latch the lower segment bound.
        logic seg_hi;       // Latch the upper segment bound.
        logic div_level;    // Start the ramp division.
        logic take_level;   // Latch the ramp level.
        logic load_out;     // Load the result register.
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic redline_zero;
        logic below_start;
        logic at_redline;
        logic small_range;
        logic ramp_ok;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/rpm_shift_light_bar_core.sv =====
// Top level of the RPM shift-light bar core: configuration register, controller
// and datapath. Depends on rpmsl_pkg, rpmsl_ctrl and rpmsl_dp.
//
// Each input beat (engine speed, redline, millisecond time) yields one result
// beat with the bar mode and nine LED levels, except that a zero redline yields
// none. The block works on one beat at a time. A beat below the start point or
// at redline goes from the decide state straight to the emit state; after a zero
// redline the controller returns to idle. A fill-mode beat makes up to two
// passes through the shared one-bit-per-cycle divider (23 steps each), one for
// the active LED index and one for its ramp level. The index division is skipped
// when the span from start point to redline is below nine counts, and the ramp
// division when the active segment is empty or the speed lies below it. The
// input is ready again in the cycle after a result is loaded. A waiting result
// sits in an output register, so the next beat is accepted and worked through
// while it waits, then holds in the controller until the waiting result is
// taken. The blink interval register sits at byte address 0 of the APB port,
// resets to 100 ms and should be written only while the block is idle.
module rpm_shift_light_bar_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_rpm_level,
    input  logic [15:0] s_redline_level,
    input  logic [31:0] s_now_ms,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_bar_mode,
    output logic [7:0]  m_led0_level,
    output logic [7:0]  m_led1_level,
    output logic [7:0]  m_led2_level,
    output logic [7:0]  m_led3_level,
    output logic [7:0]  m_led4_level,
    output logic [7:0]  m_led5_level,
    output logic [7:0]  m_led6_level,
    output logic [7:0]  m_led7_level,
    output logic [7:0]  m_led8_level
);
    import rpmsl_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  cfg_write;
    dp_cmd_t               cmd;
    dp_stat_t              stat;
    bar_mode_t             bar_mode;
    logic [LEVEL_W-1:0]    led_level [LED_COUNT];

    // Blink interval register; only address bit 2 selects a register.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= BLINK_RESET_MS;
        end else if (cfg_write && (paddr[2] == REG_BLINK_INTERVAL)) begin
            interval_reg <= pwdata[INTERVAL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLINK_INTERVAL) ? {16'h0000, interval_reg} : 32'h0;

    rpmsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rpmsl_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .rpm_level       (s_rpm_level),
        .redline_level   (s_redline_level),
        .now_ms          (s_now_ms),
        .blink_period_ms (interval_reg),
        .bar_mode        (bar_mode),
        .led_level       (led_level)
    );

    // Result fields.
    assign m_bar_mode   = bar_mode;
    assign m_led0_level = led_level[0];
    assign m_led1_level = led_level[1];
    assign m_led2_level = led_level[2];
    assign m_led3_level = led_level[3];
    assign m_led4_level = led_level[4];
    assign m_led5_level = led_level[5];
    assign m_led6_level = led_level[6];
    assign m_led7_level = led_level[7];
    assign m_led8_level = led_level[8];

endmodule

// ===== rtl/rpmsl_div.sv =====
// Iterative restoring divider for the RPM shift-light bar core.
// Produces one quotient bit per cycle; depends on rpmsl_pkg.
module rpmsl_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rpmsl_pkg::DIV_W-1:0]   dividend,
    input  logic [rpmsl_pkg::RANGE_W-1:0] divisor,
    output logic                          done,
    output logic [rpmsl_pkg::DIV_W-1:0]   quotient
);
    import rpmsl_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RANGE_W-1:0]   rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [RANGE_W-1:0]   dsr_reg;

    logic [RANGE_W:0]     shifted;
    logic                 fits;
    logic [RANGE_W:0]     diff;
    logic [RANGE_W-1:0]   rem_next;

    // One trial subtraction per cycle.
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        fits     = shifted >= {1'b0, dsr_reg};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = fits ? diff[RANGE_W-1:0] : shifted[RANGE_W-1:0];
    end

    // Sequencing of the iterations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/rpmsl_dp.sv =====
// Datapath of the RPM shift-light bar core: input latch, blink timer,
// segment arithmetic and result register. Depends on rpmsl_pkg and rpmsl_div.
module rpmsl_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rpmsl_pkg::dp_cmd_t               cmd,
    output rpmsl_pkg::dp_stat_t              stat,
    input  logic [rpmsl_pkg::RPM_W-1:0]      rpm_level,
    input  logic [rpmsl_pkg::RPM_W-1:0]      redline_level,
    input  logic [rpmsl_pkg::TIME_W-1:0]     now_ms,
    input  logic [rpmsl_pkg::INTERVAL_W-1:0] blink_period_ms,
    output rpmsl_pkg::bar_mode_t             bar_mode,
    output logic [rpmsl_pkg::LEVEL_W-1:0]    led_level [rpmsl_pkg::LED_COUNT]
);
    import rpmsl_pkg::*;

    // Latched input beat and derived span.
    logic [RPM_W-1:0]   rpm_reg;
    logic [RPM_W-1:0]   redline_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [RPM_W-1:0]   start_reg;
    logic [RANGE_W-1:0] range_reg;

    // Blink timer state.
    logic               blink_on_reg;
    logic [TIME_W-1:0]  last_toggle_reg;

    // Segment arithmetic.
    logic [LED_IDX_W-1:0] active_reg;
    logic [BOUND_W-1:0]   p_lo_reg;
    logic [BOUND_W-1:0]   p_hi_reg;
    logic [RANGE_W-1:0]   lo_reg;
    logic [RANGE_W-1:0]   hi_reg;
    logic [LEVEL_W-1:0]   level_reg;

    // Result register.
    bar_mode_t            mode_out_reg;
    logic [LEVEL_W-1:0]   led_out_reg [LED_COUNT];

    logic [RPM_W+1:0]     start_sum;
    logic [RPM_W-1:0]     start_next;
    logic [RPM_W-1:0]     range_full;
    logic [RPM_W-1:0]     rel_full;
    logic [RANGE_W-1:0]   rel;
    logic [TIME_W-1:0]    elapsed;
    logic [PROD_W-1:0]    lo_scaled;
    logic [PROD_W-1:0]    hi_scaled;
    logic [RANGE_W-1:0]   ramp_d;
    logic [DIV_W-1:0]     ramp_num;
    logic [DIV_W-1:0]     div_dividend;
    logic [RANGE_W-1:0]   div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [DIV_W-1:0]     active_pick;
    bar_mode_t            mode_now;

    // Start point is three quarters of redline, rounded down.
    always_comb begin
        start_sum  = {1'b0, redline_level, 1'b0} + {2'b00, redline_level};
        start_next = start_sum[RPM_W+1:2];
        range_full = redline_level - start_next;
    end

    // Input latch.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rpm_reg     <= rpm_level;
            redline_reg <= redline_level;
            now_reg     <= now_ms;
            start_reg   <= start_next;
            range_reg   <= range_full[RANGE_W-1:0];
        end
    end

    // In fill mode the offset from the start point is below the span.
    always_comb begin
        rel_full = rpm_reg - start_reg;
        rel      = rel_full[RANGE_W-1:0];
        ramp_d   = rel - lo_reg;
        ramp_num = {ramp_d, {LEVEL_W{1'b0}}} - DIV_W'(ramp_d);
    end

    // Status toward the controller.
    always_comb begin
        stat.redline_zero = redline_reg == '0;
        stat.below_start  = rpm_reg < start_reg;
        stat.at_redline   = rpm_reg >= redline_reg;
        stat.small_range  = range_reg < RANGE_W'(LED_COUNT);
        stat.ramp_ok      = (hi_reg > lo_reg) && (rel >= lo_reg);
        stat.div_done     = div_done;
    end

    // Blink timer: toggles once the interval has elapsed, modulo 2^32.
    assign elapsed = now_reg - last_toggle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_on_reg    <= 1'b0;
            last_toggle_reg <= '0;
        end else if (cmd.blink_step) begin
            if (elapsed >= TIME_W'(blink_period_ms)) begin
                blink_on_reg    <= ~blink_on_reg;
                last_toggle_reg <= now_reg;
            end
        end
    end

    // Shared divider: active index first, then the ramp level.
    always_comb begin
        if (cmd.div_level) begin
            div_dividend = ramp_num;
            div_divisor  = hi_reg - lo_reg;
        end else begin
            div_dividend = DIV_W'(rel) * DIV_W'(LED_COUNT);
            div_divisor  = range_reg;
        end
    end

    rpmsl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_active | cmd.div_level),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Active index, clamped to the last LED.
    always_comb begin
        active_pick = stat.small_range ? DIV_W'(rel) : div_quo;
        if (active_pick > DIV_W'(LED_COUNT - 1)) begin
            active_pick = DIV_W'(LED_COUNT - 1);
        end
    end

    // Segment bounds: products, then a reciprocal multiply for each bound.
    always_comb begin
        lo_scaled = PROD_W'(p_lo_reg) * PROD_W'(RECIP_MULT);
        hi_scaled = PROD_W'(p_hi_reg) * PROD_W'(RECIP_MULT);
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_active) begin
            active_reg <= active_pick[LED_IDX_W-1:0];
        end
        if (cmd.seg_prod) begin
            p_lo_reg <= BOUND_W'(active_reg) * BOUND_W'(range_reg);
            p_hi_reg <= BOUND_W'(active_reg) * BOUND_W'(range_reg) + BOUND_W'(range_reg);
        end
        if (cmd.seg_lo) begin
            lo_reg <= stat.small_range ? RANGE_W'(active_reg)
                                       : lo_scaled[RECIP_SHIFT +: RANGE_W];
        end
        if (cmd.seg_hi) begin
            hi_reg <= stat.small_range ? RANGE_W'(active_reg) + 1'b1
                                       : hi_scaled[RECIP_SHIFT +: RANGE_W];
        end
        if (cmd.take_level) begin
            level_reg <= stat.ramp_ok ? div_quo[LEVEL_W-1:0] : '0;
        end
    end

    // Result register: mode and one level per LED.
    always_comb begin
        if (stat.below_start) begin
            mode_now = MODE_OFF;
        end else if (stat.at_redline) begin
            mode_now = MODE_BLINK;
        end else begin
            mode_now = MODE_FILL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            mode_out_reg <= mode_now;
            for (int i = 0; i < LED_COUNT; i++) begin
                case (mode_now)
                    MODE_BLINK: begin
                        led_out_reg[i] <= blink_on_reg ? FULL_LEVEL : '0;
                    end
                    MODE_FILL: begin
                        if (LED_IDX_W'(i) < active_reg) begin
                            led_out_reg[i] <= FULL_LEVEL;
                        end else if (LED_IDX_W'(i) == active_reg) begin
                            led_out_reg[i] <= level_reg;
                        end else begin
                            led_out_reg[i] <= '0;
                        end
                    end
                    default: begin
                        led_out_reg[i] <= '0;
                    end
                endcase
            end
        end
    end

    assign bar_mode  = mode_out_reg;
    assign led_level = led_out_reg;

endmodule

// ===== rtl/rpmsl_ctrl.sv =====
// Controller of the RPM shift-light bar core: sequences one beat through the
// datapath and owns both channel handshakes. Depends on rpmsl_pkg.
module rpmsl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rpmsl_pkg::dp_stat_t  stat,
    output rpmsl_pkg::dp_cmd_t   cmd
);
    import rpmsl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_DIV_A  = 9'b000000100,
        S_PROD   = 9'b000001000,
        S_LO     = 9'b000010000,
        S_HI     = 9'b000100000,
        S_LVL    = 9'b001000000,
        S_DIV_L  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.redline_zero) begin
                    state_next = S_IDLE;
                end else if (stat.below_start) begin
                    state_next = S_EMIT;
                end else if (stat.at_redline) begin
                    cmd.blink_step = 1'b1;
                    state_next     = S_EMIT;
                end else if (stat.small_range) begin
                    cmd.take_active = 1'b1;
                    state_next      = S_PROD;
                end else begin
                    cmd.div_active = 1'b1;
                    state_next     = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (stat.div_done) begin
                    cmd.take_active = 1'b1;
                    state_next      = S_PROD;
                end
            end
            S_PROD: begin
                cmd.seg_prod = 1'b1;
                state_next   = S_LO;
            end
            S_LO: begin
                cmd.seg_lo = 1'b1;
                state_next = S_HI;
            end
            S_HI: begin
                cmd.seg_hi = 1'b1;
                state_next = S_LVL;
            end
            S_LVL: begin
                if (stat.ramp_ok) begin
                    cmd.div_level = 1'b1;
                    state_next    = S_DIV_L;
                end else begin
                    cmd.take_level = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_DIV_L: begin
                if (stat.div_done) begin
                    cmd.take_level = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat stays valid until taken.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ===== bench/tb_rpm_shift_light_bar_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rpm_shift_light_bar_core: random and directed speed beats
// against an in-bench prediction of the LED frame. Depends on rpmsl_pkg and the core.
module tb_rpm_shift_light_bar_core;
    import rpmsl_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 64;
    localparam int          CHUNK_BEATS    = 128;
    localparam int          HOLD_AT        = 120;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          SHOW_LIMIT     = 10;
    localparam logic [2:0]  ADDR_BLINK     = {REG_BLINK_INTERVAL, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED    = 3'd4;

    typedef struct packed {
        logic [RPM_W-1:0]  rpm;
        logic [RPM_W-1:0]  redline;
        logic [TIME_W-1:0] now;
    } speed_beat_t;

    typedef struct packed {
        bar_mode_t                          mode;
        logic [LED_COUNT-1:0][LEVEL_W-1:0]  lvl;
    } led_frame_t;

    // Clock, reset and driven port signals, all known from time zero.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_rpm_level = '0;
    logic [15:0] s_redline_level = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_bar_mode;
    logic [7:0]  m_led0_level, m_led1_level, m_led2_level, m_led3_level, m_led4_level;
    logic [7:0]  m_led5_level, m_led6_level, m_led7_level, m_led8_level;

    // Bench state shared between processes.
    speed_beat_t beat_q[$];
    led_frame_t  frame_q[$];
    int          beats_queued = 0;
    int          beats_in = 0;
    int          frames_out = 0;
    int          toggles = 0;
    int          fail_count = 0;
    int          shown = 0;
    int          src_idle_pct = 0;
    int          dst_stall_pct = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          beat_taken = 1'b0;
    int          idle_cycles = 0;
    logic [31:0] clock_ms = '0;

    // Predicted copy of the block's register and blink state.
    logic [INTERVAL_W-1:0] interval_ms = BLINK_RESET_MS;
    logic                  blink_lit = 1'b0;
    logic [TIME_W-1:0]     toggle_ms = '0;

    rpm_shift_light_bar_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rpm_level     (s_rpm_level),
        .s_redline_level (s_redline_level),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bar_mode      (m_bar_mode),
        .m_led0_level    (m_led0_level),
        .m_led1_level    (m_led1_level),
        .m_led2_level    (m_led2_level),
        .m_led3_level    (m_led3_level),
        .m_led4_level    (m_led4_level),
        .m_led5_level    (m_led5_level),
        .m_led6_level    (m_led6_level),
        .m_led7_level    (m_led7_level),
        .m_led8_level    (m_led8_level)
    );

    always #1 aclk = ~aclk;

    // Edge of segment i: the span is cut evenly, or one count per LED when it is short.
    function automatic int unsigned seg_edge(input int unsigned i, input int unsigned span);
        if (span < LED_COUNT) return i;
        return (i * span) / LED_COUNT;
    endfunction

    // Work out the frame for one speed beat; returns 0 when the beat yields no frame.
    function automatic bit predict_frame(input speed_beat_t b, output led_frame_t f);
        int unsigned start_pt, span, rel, active, lo, hi, level;
        f = '0;
        if (b.redline == 0) return 1'b0;
        start_pt = (3 * int'(b.redline)) / 4;
        if (b.rpm < start_pt) begin
            f.mode = MODE_OFF;
            return 1'b1;
        end
        if (b.rpm >= b.redline) begin
            if (TIME_W'(b.now - toggle_ms) >= interval_ms) begin
                blink_lit = ~blink_lit;
                toggle_ms = b.now;
                toggles++;
            end
            f.mode = MODE_BLINK;
            for (int i = 0; i < LED_COUNT; i++) f.lvl[i] = blink_lit ? FULL_LEVEL : '0;
            return 1'b1;
        end
        span = b.redline - start_pt;
        rel = b.rpm - start_pt;
        active = (span < LED_COUNT) ? rel : (LED_COUNT * rel) / span;
        if (active > LED_COUNT - 1) active = LED_COUNT - 1;
        f.mode = MODE_FILL;
        for (int i = 0; i < LED_COUNT; i++) begin
            if (i < active) begin
                f.lvl[i] = FULL_LEVEL;
            end else if (i == active) begin
                lo = seg_edge(i, span);
                hi = seg_edge(i + 1, span);
                level = (hi > lo && rel >= lo) ? ((rel - lo) * 255) / (hi - lo) : 0;
                f.lvl[i] = level[LEVEL_W-1:0];
            end
        end
        return 1'b1;
    endfunction

    // Random beat: mostly valid redlines with the speed in the fill window,
    // plus dark, redline and zero-redline beats and a jittery, wrapping clock.
    function automatic speed_beat_t random_beat();
        speed_beat_t b;
        int unsigned pick, start_pt;
        pick = $urandom_range(0, 99);
        if (pick < 40) b.redline = 16'($urandom_range(1, 40));
        else if (pick < 90) b.redline = 16'($urandom_range(1, 65535));
        else b.redline = 16'($urandom_range(65000, 65535));
        start_pt = (3 * int'(b.redline)) / 4;
        pick = $urandom_range(0, 99);
        if (pick < 55) b.rpm = 16'($urandom_range(start_pt, b.redline - 1));
        else if (pick < 70) b.rpm = (start_pt == 0) ? 16'd0 : 16'($urandom_range(0, start_pt - 1));
        else if (pick < 85) b.rpm = 16'($urandom_range(b.redline, 65535));
        else if (pick < 92) b.rpm = b.redline;
        else b.rpm = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 6) b.redline = '0;
        pick = $urandom_range(0, 99);
        if (pick < 50) clock_ms += $urandom_range(0, 200);
        else if (pick < 80) clock_ms += $urandom_range(0, 70000);
        else if (pick < 90) clock_ms = $urandom();
        else clock_ms -= $urandom_range(1, 5000);
        b.now = clock_ms;
        return b;
    endfunction

    task automatic queue_beat(input logic [15:0] rpm, input logic [15:0] redline,
                              input logic [31:0] now);
        beat_q.push_back('{rpm: rpm, redline: redline, now: now});
        beats_queued++;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (shown < SHOW_LIMIT) begin
            shown++;
            $display("mismatch on %s: expected 0x%0h, got 0x%0h (frame %0d)",
                     what, want, got, frames_out);
        end
    endtask

    // Wait until every queued beat is in and every predicted frame is out.
    task automatic wait_drained();
        while (beats_in != beats_queued || frame_q.size() != 0) @(negedge aclk);
    endtask

    // APB write, then read the interval register back and check it.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        logic        rdy;
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (addr == ADDR_BLINK) interval_ms = data[INTERVAL_W-1:0];
        pwrite <= 1'b0; penable <= 1'b0; paddr <= ADDR_BLINK;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        rdy = pready;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
        if (rdy !== 1'b1)
            note_mismatch("pready", 32'd1, {31'd0, rdy});
        if (rd[INTERVAL_W-1:0] !== interval_ms)
            note_mismatch("blink interval readback", interval_ms, rd);
    endtask

    // Sender: offers a new beat from the queue when the last one was taken.
    always @(negedge aclk) begin : sender
        speed_beat_t nxt;
        bit offer;
        offer = s_valid && !beat_taken;
        beat_taken = 1'b0;
        if (!offer && aresetn && beat_q.size() != 0) begin
            if ($urandom_range(0, 99) >= src_idle_pct) begin
                nxt = beat_q.pop_front();
                s_rpm_level <= nxt.rpm;
                s_redline_level <= nxt.redline;
                s_now_ms <= nxt.now;
                offer = 1'b1;
            end
        end
        s_valid <= offer;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge aclk) begin : receiver
        bit take;
        if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
        end else if (!hold_done && frames_out >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            take = 1'b0;
        end else begin
            take = ($urandom_range(0, 99) >= dst_stall_pct);
        end
        m_ready <= take;
    end

    // Monitor: predicts on each input beat, checks each result beat, runs the watchdog.
    always @(posedge aclk) begin : monitor
        led_frame_t want, got;
        bit moved;
        moved = 1'b0;
        if (aresetn && s_valid && s_ready) begin
            beat_taken = 1'b1;
            moved = 1'b1;
            beats_in++;
            if (predict_frame({s_rpm_level, s_redline_level, s_now_ms}, want))
                frame_q.push_back(want);
        end
        if (aresetn && m_valid && m_ready) begin
            moved = 1'b1;
            got.mode = bar_mode_t'(m_bar_mode);
            got.lvl = {m_led8_level, m_led7_level, m_led6_level, m_led5_level, m_led4_level,
                       m_led3_level, m_led2_level, m_led1_level, m_led0_level};
            if (frame_q.size() == 0) begin
                note_mismatch("unexpected result beat", '0, got.mode);
            end else begin
                want = frame_q.pop_front();
                if (got.mode !== want.mode) note_mismatch("bar_mode", want.mode, got.mode);
                for (int i = 0; i < LED_COUNT; i++)
                    if (got.lvl[i] !== want.lvl[i])
                        note_mismatch($sformatf("led%0d_level", i), want.lvl[i], got.lvl[i]);
            end
            frames_out++;
        end
        idle_cycles = (moved || !aresetn) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d frames still expected",
                     idle_cycles, frame_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence: directed beats, then random phases under several settings.
    initial begin : stimulus
        logic [INTERVAL_W-1:0] phase_interval[6];
        phase_interval = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd100, 16'd0};
        phase_interval[3] = 16'($urandom_range(2, 65534));
        phase_interval[5] = 16'($urandom_range(2, 300));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero redline yields nothing, whatever the speed.
        queue_beat(16'hFFFF, 16'h0000, 32'd0);
        queue_beat(16'h0000, 16'h0000, 32'hFFFF_FFFF);
        // Below the start point.
        queue_beat(16'h0000, 16'hFFFF, 32'd0);
        queue_beat(16'd49150, 16'hFFFF, 32'd1);
        // Blink timing at the reset interval, including a backwards clock step.
        queue_beat(16'hFFFF, 16'hFFFF, 32'd0);
        queue_beat(16'hFFFF, 16'hFFFF, 32'd100);
        queue_beat(16'hFFFF, 16'hFFFF, 32'd150);
        queue_beat(16'hFFFF, 16'hFFFF, 32'd200);
        queue_beat(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_beat(16'hFFFF, 16'hFFFF, 32'hFFFF_FF00);
        queue_beat(16'hFFFF, 16'hFFFF, 32'hFFFF_FF01);
        // Fill across the widest window.
        queue_beat(16'd49151, 16'hFFFF, 32'd5);
        queue_beat(16'd57343, 16'hFFFF, 32'd6);
        queue_beat(16'd65534, 16'hFFFF, 32'd7);
        queue_beat(16'd8000, 16'd10000, 32'd8);
        // Short windows, including spans below nine counts.
        queue_beat(16'd0, 16'd1, 32'd9);
        queue_beat(16'd1, 16'd1, 32'd10);
        queue_beat(16'd3, 16'd4, 32'd11);
        queue_beat(16'd7, 16'd8, 32'd12);
        queue_beat(16'd27, 16'd36, 32'd13);
        queue_beat(16'd35, 16'd36, 32'd14);
        queue_beat(16'd39, 16'd40, 32'd15);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        // A write to an unused index must leave the interval alone.
        write_reg(ADDR_UNUSED, 32'd7);

        for (int p = 0; p < 6; p++) begin
            write_reg(ADDR_BLINK, {16'd0, phase_interval[p]});
            case (p % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 81; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 81; end
                default: begin src_idle_pct = 16; dst_stall_pct = 16; end
            endcase
            // Two chunks per phase; the next chunk is queued only once the block has drained.
            for (int c = 0; c < 2; c++) begin
                for (int n = 0; n < CHUNK_BEATS; n++) begin
                    beat_q.push_back(random_beat());
                    beats_queued++;
                end
                wait_drained();
            end
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end

        fail_count += frame_q.size();
        $display("Summary: %0d speed beats in, %0d LED frames checked, %0d blink toggles, %0d mismatches.",
                 beats_in, frames_out, toggles, fail_count);
        $display("Covered intervals 0, 1, 100, 65535 and random ones; idle, stall and hold-off.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
